// ----- rtl/rvx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rvx_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int REG_COUNT = 32;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int CLR_LEN   = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;
    localparam int CLR_W     = $clog2(CLR_LEN);

    localparam logic [2:0] MODE_EXEC = 3'd0;
    localparam logic [2:0] MODE_WREG = 3'd1;
    localparam logic [2:0] MODE_WMEM = 3'd2;
    localparam logic [2:0] MODE_RREG = 3'd3;
    localparam logic [2:0] MODE_RMEM = 3'd4;

    localparam logic [6:0] OPC_IMM   = 7'h13;
    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_REG   = 7'h33;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] F7_ADD    = 7'h00;
    localparam logic [6:0] F7_SUB    = 7'h20;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNSUP = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        K_NONE,
        K_ADD,
        K_SUB,
        K_ADDI,
        K_LOAD,
        K_STORE,
        K_WREG,
        K_WMEM,
        K_RREG,
        K_RMEM
    } kind_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] instruction;
        logic [9:0]  slot;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        kind_t             kind;
        logic [REG_AW-1:0] rs1;
        logic [REG_AW-1:0] rs2;
        logic [REG_AW-1:0] rd;
        logic [31:0]       imm;
        logic [MEM_AW-1:0] maddr;
        logic [1:0]        status;
    } dec_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/rv32_subset_executor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Executes one request per beat (execute an add, sub, addi, lw or sw instruction, or write or
// read one register or memory word) and returns one response beat for each, in order. The
// block sustains one request per cycle unless responses are held off. Each request passes the
// queue, the operand-read stage and the response stage; register-file and memory reads are
// registered. A two-entry queue decouples decode from execution, so requests are still taken
// while a response waits, until the queue fills. After reset a clearing pass zeroes the data
// memory and register file, one word per cycle over 1024 addresses; req_ready stays low until it ends.
module rv32_subset_executor_unit import rvx_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    ctl_t ctl;
    logic head_valid;
    dec_t head;

    rvx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head       (head)
    );

    rvx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .ctl        (ctl),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/rvx_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rvx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rvx_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rvx_front import rvx_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    input  wire ctl_t ctl,
    output logic      head_valid,
    output dec_t      head
);

    dec_t       dec;
    dec_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic [6:0] opc;
    logic [6:0] f7;

    assign opc = req.instruction[6:0];
    assign f7  = req.instruction[31:25];

    always_comb
    begin
        dec.kind   = K_NONE;
        dec.rs1    = req.instruction[19:15];
        dec.rs2    = req.instruction[24:20];
        dec.rd     = req.instruction[11:7];
        dec.imm    = {{20{req.instruction[31]}}, req.instruction[31:20]};
        dec.maddr  = MEM_AW'(req.slot);
        dec.status = ST_OK;
        unique case (req.mode) inside
            MODE_EXEC:
            begin
                unique case (opc)
                    OPC_IMM:   dec.kind = K_ADDI;
                    OPC_LOAD:  dec.kind = K_LOAD;
                    OPC_STORE:
                    begin
                        dec.kind = K_STORE;
                        dec.imm  = {{20{req.instruction[31]}}, req.instruction[31:25],
                                    req.instruction[11:7]};
                    end
                    OPC_REG:
                    begin
                        if (f7 == F7_ADD)
                        begin
                            dec.kind = K_ADD;
                        end
                        else if (f7 == F7_SUB)
                        begin
                            dec.kind = K_SUB;
                        end
                        else
                        begin
                            dec.status = ST_UNSUP;
                        end
                    end
                    default:   dec.status = ST_UNSUP;
                endcase
            end
            MODE_WREG, MODE_RREG:
            begin
                if (32'(req.slot) < 32'(REG_COUNT))
                begin
                    dec.kind = (req.mode == MODE_WREG) ? K_WREG : K_RREG;
                    dec.rd   = REG_AW'(req.slot);
                    dec.rs1  = REG_AW'(req.slot);
                    dec.imm  = req.value;
                end
                else
                begin
                    dec.status = ST_RANGE;
                end
            end
            MODE_WMEM, MODE_RMEM:
            begin
                if (32'(req.slot) < 32'(MEM_WORDS))
                begin
                    dec.kind = (req.mode == MODE_WMEM) ? K_WMEM : K_RMEM;
                    dec.imm  = req.value;
                end
                else
                begin
                    dec.status = ST_RANGE;
                end
            end
            default: dec.status = ST_UNSUP;
        endcase
    end

    assign req_ready  = (count_reg != 2'd2) && !ctl.clearing;
    assign push       = req_valid && req_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !ctl.pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && ctl.pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rvx_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rvx_back import rvx_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire dec_t head,
    output ctl_t      ctl,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic              adv;
    logic              pop;
    logic              clearing_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;

    logic              b_valid_reg;
    dec_t              b_reg;

    logic              c_valid_reg;
    logic              c_we_reg;
    logic              c_from_mem_reg;
    logic              c_show_mem_reg;
    logic [REG_AW-1:0] c_rd_reg;
    logic [31:0]       c_data_reg;
    logic [31:0]       c_rdata_reg;
    logic [1:0]        c_status_reg;

    logic              c_we_next;
    logic              c_from_mem_next;
    logic              c_show_mem_next;
    logic [31:0]       c_data_next;
    logic [31:0]       c_rdata_next;
    logic [1:0]        c_status_next;

    logic              fwd_we_reg;
    logic [REG_AW-1:0] fwd_rd_reg;
    logic [31:0]       fwd_data_reg;

    logic [31:0]       rf_q1;
    logic [31:0]       rf_q2;
    logic [31:0]       mem_q;
    logic [31:0]       c_wdata;
    logic [31:0]       op1;
    logic [31:0]       op2;
    logic [31:0]       alu_b;
    logic [31:0]       sum;
    logic [31:0]       diff;
    logic              idx_ok;
    logic              rd_nz;

    logic              b_mem_we;
    logic [MEM_AW-1:0] b_maddr;
    logic [31:0]       b_mem_wdata;

    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    assign adv          = !c_valid_reg || rsp_ready;
    assign pop          = adv && head_valid && !clearing_reg;
    assign ctl.pop      = pop;
    assign ctl.clearing = clearing_reg;

    assign c_wdata = c_from_mem_reg ? mem_q : c_data_reg;

    // Register 0 reads as zero; other operands take the newest value: the item now in writeback,
    // then the write that landed as the operands were being read, then the register file.
    always_comb
    begin
        if (b_reg.rs1 == '0)
        begin
            op1 = '0;
        end
        else if (c_valid_reg && c_we_reg && (c_rd_reg == b_reg.rs1))
        begin
            op1 = c_wdata;
        end
        else if (fwd_we_reg && (fwd_rd_reg == b_reg.rs1))
        begin
            op1 = fwd_data_reg;
        end
        else
        begin
            op1 = rf_q1;
        end

        if (b_reg.rs2 == '0)
        begin
            op2 = '0;
        end
        else if (c_valid_reg && c_we_reg && (c_rd_reg == b_reg.rs2))
        begin
            op2 = c_wdata;
        end
        else if (fwd_we_reg && (fwd_rd_reg == b_reg.rs2))
        begin
            op2 = fwd_data_reg;
        end
        else
        begin
            op2 = rf_q2;
        end
    end

    assign alu_b  = (b_reg.kind == K_ADD) ? op2 : b_reg.imm;
    assign sum    = op1 + alu_b;
    assign diff   = op1 - op2;
    assign idx_ok = {2'b00, sum[31:2]} < 32'(MEM_WORDS);
    assign rd_nz  = (b_reg.rd != '0);

    always_comb
    begin
        c_we_next       = 1'b0;
        c_from_mem_next = 1'b0;
        c_show_mem_next = 1'b0;
        c_data_next     = sum;
        c_rdata_next    = '0;
        c_status_next   = ST_OK;
        b_mem_we        = 1'b0;
        b_maddr         = MEM_AW'(sum[31:2]);
        b_mem_wdata     = op2;
        unique case (b_reg.kind) inside
            K_ADD, K_ADDI:
            begin
                c_we_next = rd_nz;
            end
            K_SUB:
            begin
                c_we_next   = rd_nz;
                c_data_next = diff;
            end
            K_LOAD:
            begin
                if (idx_ok)
                begin
                    c_we_next       = rd_nz;
                    c_from_mem_next = 1'b1;
                end
                else
                begin
                    c_status_next = ST_RANGE;
                end
            end
            K_STORE:
            begin
                if (idx_ok)
                begin
                    b_mem_we = 1'b1;
                end
                else
                begin
                    c_status_next = ST_RANGE;
                end
            end
            K_WREG:
            begin
                c_we_next   = rd_nz;
                c_data_next = b_reg.imm;
            end
            K_WMEM:
            begin
                b_mem_we    = 1'b1;
                b_maddr     = b_reg.maddr;
                b_mem_wdata = b_reg.imm;
            end
            K_RREG:
            begin
                c_rdata_next = op1;
            end
            K_RMEM:
            begin
                c_show_mem_next = 1'b1;
                b_maddr         = b_reg.maddr;
            end
            K_NONE:
            begin
                c_status_next = b_reg.status;
            end
            default:
            begin
                c_status_next = ST_UNSUP;
            end
        endcase
    end

    assign rf_we     = clearing_reg || (adv && c_valid_reg && c_we_reg);
    assign rf_waddr  = clearing_reg ? REG_AW'(clr_cnt_reg) : c_rd_reg;
    assign rf_wdata  = clearing_reg ? '0 : c_wdata;

    assign mem_we    = clearing_reg ? (32'(clr_cnt_reg) < 32'(MEM_WORDS))
                                    : (adv && b_valid_reg && b_mem_we);
    assign mem_waddr = clearing_reg ? MEM_AW'(clr_cnt_reg) : b_maddr;
    assign mem_wdata = clearing_reg ? '0 : b_mem_wdata;

    rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (adv),
        .raddr (head.rs1),
        .rdata (rf_q1)
    );

    rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (adv),
        .raddr (head.rs2),
        .rdata (rf_q2)
    );

    rvx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (adv),
        .raddr (b_maddr),
        .rdata (mem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            fwd_we_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                b_valid_reg <= pop;
                c_valid_reg <= b_valid_reg;
                fwd_we_reg  <= c_valid_reg && c_we_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg          <= head;
            c_we_reg       <= c_we_next;
            c_from_mem_reg <= c_from_mem_next;
            c_show_mem_reg <= c_show_mem_next;
            c_rd_reg       <= b_reg.rd;
            c_data_reg     <= c_data_next;
            c_rdata_reg    <= c_rdata_next;
            c_status_reg   <= c_status_next;
            fwd_rd_reg     <= c_rd_reg;
            fwd_data_reg   <= c_wdata;
        end
    end

    assign rsp_valid     = c_valid_reg;
    assign rsp.read_data = c_show_mem_reg ? mem_q : c_rdata_reg;
    assign rsp.status    = c_status_reg;

endmodule

`default_nettype wire

// ----- rtl/rvx_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rvx_checker import rvx_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request beat changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.read_data == 32'd0)
        else $error("failed response carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK) || (rsp.status == ST_UNSUP) ||
                      (rsp.status == ST_RANGE))
        else $error("response status code out of range");

    a_clear_first: assert property (@(posedge clk)
        $rose(rst_n) |-> !req_ready && !rsp_valid)
        else $error("block active before memory clear");

endmodule

bind rv32_subset_executor_unit rvx_checker u_rvx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ----- test/rvx_response_checker.sv -----
`timescale 1ns / 1ps

module rvx_response_checker import rvx_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   errors,
    output int   outstanding,
    output int   checked
);

    logic [31:0] gpr [REG_COUNT];
    logic [31:0] dmem [MEM_WORDS];
    rsp_t        predicted_rsp [$];
    rsp_t        want;

    function automatic logic [31:0] gpr_read(input logic [4:0] n);
        return (n == '0) ? '0 : gpr[n];
    endfunction

    function automatic void gpr_write(input logic [4:0] n, input logic [31:0] v);
        if (n != '0)
            gpr[n] = v;
    endfunction

    function automatic logic [1:0] run_instruction(input logic [31:0] ins);
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] addr;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [6:0]  f7;
        logic [1:0]  st;
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        rd    = ins[11:7];
        rs1   = ins[19:15];
        rs2   = ins[24:20];
        f7    = ins[31:25];
        st    = ST_OK;
        case (ins[6:0])
            OPC_IMM:
                gpr_write(rd, gpr_read(rs1) + imm_i);
            OPC_LOAD:
            begin
                addr = gpr_read(rs1) + imm_i;
                if (addr[31:2] >= MEM_WORDS)
                    st = ST_RANGE;
                else
                    gpr_write(rd, dmem[addr[11:2]]);
            end
            OPC_STORE:
            begin
                addr = gpr_read(rs1) + imm_s;
                if (addr[31:2] >= MEM_WORDS)
                    st = ST_RANGE;
                else
                    dmem[addr[11:2]] = gpr_read(rs2);
            end
            OPC_REG:
            begin
                if (f7 == F7_ADD)
                    gpr_write(rd, gpr_read(rs1) + gpr_read(rs2));
                else if (f7 == F7_SUB)
                    gpr_write(rd, gpr_read(rs1) - gpr_read(rs2));
                else
                    st = ST_UNSUP;
            end
            default:
                st = ST_UNSUP;
        endcase
        return st;
    endfunction

    function automatic rsp_t execute_request(input req_t r);
        rsp_t res;
        res = '0;
        case (r.mode)
            MODE_EXEC:
                res.status = run_instruction(r.instruction);
            MODE_WREG:
            begin
                if (r.slot >= REG_COUNT)
                    res.status = ST_RANGE;
                else
                    gpr_write(r.slot[4:0], r.value);
            end
            MODE_WMEM:
            begin
                if (r.slot >= MEM_WORDS)
                    res.status = ST_RANGE;
                else
                    dmem[r.slot] = r.value;
            end
            MODE_RREG:
            begin
                if (r.slot >= REG_COUNT)
                    res.status = ST_RANGE;
                else
                    res.read_data = gpr_read(r.slot[4:0]);
            end
            MODE_RMEM:
            begin
                if (r.slot >= MEM_WORDS)
                    res.status = ST_RANGE;
                else
                    res.read_data = dmem[r.slot];
            end
            default:
                res.status = ST_UNSUP;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s got %h, expected %h", $realtime, what, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                gpr[i] = '0;
            for (int i = 0; i < MEM_WORDS; i++)
                dmem[i] = '0;
            predicted_rsp.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_rsp.size() == 0)
                    report_mismatch("response beat with nothing pending", rsp.read_data, '0);
                else
                begin
                    want = predicted_rsp.pop_front();
                    checked++;
                    if (rsp.read_data !== want.read_data)
                        report_mismatch("read_data", rsp.read_data, want.read_data);
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                end
            end
            if (req_valid && req_ready)
                predicted_rsp.push_back(execute_request(req));
        end
        outstanding = predicted_rsp.size();
    end

endmodule

// ----- test/rv32_subset_executor_unit_tb.sv -----
`timescale 1ns / 1ps

module rv32_subset_executor_unit_tb;
    import rvx_pkg::*;

    localparam int         LIMIT         = 400000;
    localparam int         RANDOM_ITEMS  = 1700;
    localparam int         HOLD_CYCLES   = 400;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [6:0] OPC_UNKNOWN   = 7'h7f;
    localparam logic [6:0] F7_ODD        = 7'h01;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int errors;
    int outstanding;
    int checked;
    int sent;
    int cycles;
    int hold_left;
    bit calm;
    bit hold_pending;

    rv32_subset_executor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    rvx_response_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_REG};
    endfunction

    function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [11:0] imm,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    task automatic issue(input logic [2:0] md, input logic [31:0] ins,
                         input logic [9:0] slt, input logic [31:0] val);
        if (!calm)
            while ($urandom_range(99) < 19)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid <= 1'b1;
        req       <= '{mode: md, instruction: ins, slot: slt, value: val};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent++;
    endtask

    // Response side: random back-pressure, a quiet stretch, and one long hold-off.
    initial
    begin
        rsp_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (calm)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 19);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("rv32_subset_executor_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        int          roll;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  base;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [9:0]  slt;
        logic [31:0] val;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        calm         = 1'b0;
        hold_pending = 1'b0;
        sent         = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        issue(MODE_RREG, '0, 10'd0, '0);
        issue(MODE_WREG, '0, 10'd0, 32'hffff_ffff);
        issue(MODE_RREG, '0, 10'd0, '0);
        issue(MODE_WREG, '0, 10'd31, 32'hffff_ffff);
        issue(MODE_WREG, '0, 10'd1, 32'h8000_0000);
        issue(MODE_RREG, '0, 10'd31, '0);
        issue(MODE_WREG, '0, 10'(REG_COUNT), 32'h1234_5678);
        issue(MODE_RREG, '0, 10'h3ff, '0);
        issue(MODE_WMEM, '0, 10'h3ff, 32'ha5a5_a5a5);
        issue(MODE_RMEM, '0, 10'h3ff, '0);
        issue(MODE_RMEM, '0, 10'd0, '0);
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            issue(3'(m), 32'hffff_ffff, 10'h3ff, 32'hffff_ffff);
        issue(MODE_EXEC, enc_i(OPC_IMM, 12'h800, 5'd0, 3'd7, 5'd2), '0, '0);
        issue(MODE_EXEC, enc_i(OPC_IMM, 12'h7ff, 5'd0, 3'd0, 5'd3), '0, '0);
        issue(MODE_EXEC, enc_i(OPC_IMM, 12'd5, 5'd31, 3'd0, 5'd0), '0, '0);
        issue(MODE_EXEC, enc_r(F7_ADD, 5'd1, 5'd31, 3'd5, 5'd4), '0, '0);
        issue(MODE_EXEC, enc_r(F7_SUB, 5'd31, 5'd0, 3'd0, 5'd5), '0, '0);
        issue(MODE_EXEC, enc_r(F7_ODD, 5'd1, 5'd31, 3'd0, 5'd8), '0, '0);
        issue(MODE_EXEC, enc_i(OPC_UNKNOWN, 12'hfff, 5'd31, 3'd7, 5'd9), '0, '0);
        issue(MODE_EXEC, enc_s(12'd4, 5'd31, 5'd0, 3'd2), '0, '0);
        issue(MODE_EXEC, enc_i(OPC_LOAD, 12'd5, 5'd0, 3'd2, 5'd6), '0, '0);
        issue(MODE_EXEC, enc_i(OPC_LOAD, 12'd0, 5'd31, 3'd2, 5'd7), '0, '0);
        issue(MODE_EXEC, enc_s(12'h7ff, 5'd1, 5'd3, 3'd2), '0, '0);
        issue(MODE_EXEC, enc_s(12'd0, 5'd1, 5'd2, 3'd2), '0, '0);
        issue(MODE_RMEM, '0, 10'h3ff, '0);
        issue(MODE_RREG, '0, 10'd6, '0);
        issue(MODE_RREG, '0, 10'd4, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 500 && n < 800);
            if (n == 1200)
                hold_pending = 1'b1;
            roll = $urandom_range(99);
            rd   = 5'($urandom);
            rs1  = 5'($urandom);
            rs2  = 5'($urandom);
            f3   = 3'($urandom);
            base = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom);
            imm  = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(1023));
            slt  = 10'($urandom);
            val  = ($urandom_range(1) == 0) ? $urandom : $urandom_range(4095);
            if (n % 16 == 0)
                issue(MODE_WREG, $urandom, 10'($urandom_range(3, 1)), $urandom_range(4095));
            else if (roll < 14)
                issue(MODE_EXEC, enc_i(OPC_IMM, imm, rs1, f3, rd), slt, val);
            else if (roll < 26)
                issue(MODE_EXEC, enc_r(F7_ADD, rs2, rs1, f3, rd), slt, val);
            else if (roll < 38)
                issue(MODE_EXEC, enc_r(F7_SUB, rs2, rs1, f3, rd), slt, val);
            else if (roll < 52)
                issue(MODE_EXEC, enc_i(OPC_LOAD, imm, base, f3, rd), slt, val);
            else if (roll < 66)
                issue(MODE_EXEC, enc_s(imm, rs2, base, f3), slt, val);
            else if (roll < 72)
                issue(MODE_EXEC, $urandom, slt, val);
            else if (roll < 74)
                issue(MODE_EXEC, enc_r(7'($urandom), rs2, rs1, f3, rd), slt, val);
            else if (roll < 80)
                issue(MODE_WREG, $urandom,
                      ($urandom_range(99) < 85) ? 10'($urandom_range(31)) : slt, val);
            else if (roll < 86)
                issue(MODE_WMEM, $urandom,
                      ($urandom_range(1) == 0) ? 10'($urandom_range(255)) : slt, $urandom);
            else if (roll < 92)
                issue(MODE_RREG, $urandom,
                      ($urandom_range(99) < 85) ? 10'($urandom_range(31)) : slt, val);
            else if (roll < 98)
                issue(MODE_RMEM, $urandom,
                      ($urandom_range(1) == 0) ? 10'($urandom_range(255)) : slt, val);
            else
                issue(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), $urandom, slt, val);
        end

        req_valid <= 1'b0;
        calm = 1'b1;
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests (all modes, add/sub/addi/lw/sw, raw words, bad slots).",
                 sent);
        $display("Checked %0d response beats, including a long response hold-off; %0d errors.",
                 checked, errors);
        if (errors == 0 && outstanding == 0)
            $display("rv32_subset_executor_unit_tb OK");
        else
            $display("rv32_subset_executor_unit_tb NOT OK");
        $finish;
    end

endmodule
